[rtl/efi_pkg.sv]
// Package for the escape-time fractal iterator.
// Holds default sizes, register indexes, the controller state type and the
// command/status structs shared by the controller, the datapath and the top level.
package efi_pkg;

    localparam int DEF_WORD_WIDTH  = 32;
    localparam int DEF_FRAC_BITS   = 28;
    localparam int DEF_COUNT_WIDTH = 16;
    localparam int LIMIT_RESET     = 256;

    // Configuration register indexes; each register sits at one word address.
    typedef enum logic [1:0] {
        REG_MODE,
        REG_C_REAL,
        REG_C_IMAG,
        REG_LIMIT
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_HOLD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // take a new point and set up z and c
        logic mul;    // register the three products of the current z
        logic step;   // replace z with the new iterate and count it
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic escaped;   // |z|^2 of the current z reached 4
        logic at_limit;  // iteration count equals the limit
        logic first;     // z is still the starting value
    } t_dp_stat;

endpackage

[rtl/efi_ctrl.sv]
// Controller of the escape-time fractal iterator.
// Sequences load, multiply and update steps for one point at a time.
// Depends on efi_pkg.
module efi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_free,
    input  efi_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output logic              o_out_load,
    output efi_pkg::t_dp_cmd  o_cmd
);
    import efi_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_finish;

    // A point is done once the current iterate has escaped or the limit is used up.
    assign w_finish = (!i_stat.first && i_stat.escaped) || i_stat.at_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                n_state = w_finish ? ST_HOLD : ST_MUL;
            end
            ST_HOLD: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        o_out_load = (r_state == ST_HOLD) && i_out_free;
        o_cmd.load = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.mul  = (r_state == ST_MUL);
        o_cmd.step = (r_state == ST_UPD) && !w_finish;
    end

endmodule

[rtl/efi_datapath.sv]
// Datapath of the escape-time fractal iterator.
// Holds z, c, the three registered products and the iteration counter.
// Depends on efi_pkg.
module efi_datapath #(
    parameter int WORD_WIDTH  = efi_pkg::DEF_WORD_WIDTH,
    parameter int FRAC_BITS   = efi_pkg::DEF_FRAC_BITS,
    parameter int COUNT_WIDTH = efi_pkg::DEF_COUNT_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  efi_pkg::t_dp_cmd              i_cmd,
    input  logic                          i_mode,
    input  logic signed [WORD_WIDTH-1:0]  i_jc_re,
    input  logic signed [WORD_WIDTH-1:0]  i_jc_im,
    input  logic        [COUNT_WIDTH-1:0] i_limit,
    input  logic signed [WORD_WIDTH-1:0]  i_pt_re,
    input  logic signed [WORD_WIDTH-1:0]  i_pt_im,
    output efi_pkg::t_dp_stat             o_stat,
    output logic        [COUNT_WIDTH-1:0] o_res_count,
    output logic                          o_res_esc
);
    import efi_pkg::*;

    localparam int PW = 2 * WORD_WIDTH;
    localparam logic [PW:0] ESC_LIM = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

    logic signed [WORD_WIDTH-1:0]  r_zr;
    logic signed [WORD_WIDTH-1:0]  r_zi;
    logic signed [WORD_WIDTH-1:0]  r_cr;
    logic signed [WORD_WIDTH-1:0]  r_ci;
    logic signed [PW-1:0]          r_prr;
    logic signed [PW-1:0]          r_pii;
    logic signed [PW-1:0]          r_pri;
    logic        [COUNT_WIDTH-1:0] r_cnt;

    logic signed [PW-1:0]          w_mrr;
    logic signed [PW-1:0]          w_mii;
    logic signed [PW-1:0]          w_mri;
    logic signed [WORD_WIDTH-1:0]  w_rr;
    logic signed [WORD_WIDTH-1:0]  w_ii;
    logic signed [WORD_WIDTH-1:0]  w_ri;
    logic signed [PW-1:0]          w_sum_re;
    logic signed [PW-1:0]          w_sum_im;
    logic signed [WORD_WIDTH-1:0]  w_new_zr;
    logic signed [WORD_WIDTH-1:0]  w_new_zi;
    logic        [PW:0]            w_mag2;
    logic                          w_esc;

    // Clamp a double-width value to the word range.
    function automatic logic signed [WORD_WIDTH-1:0] sat_w(input logic signed [PW-1:0] v);
        logic fits;
        fits = (&v[PW-1:WORD_WIDTH-1]) || !(|v[PW-1:WORD_WIDTH-1]);
        if (fits) begin
            return v[WORD_WIDTH-1:0];
        end else if (v[PW-1]) begin
            return {1'b1, {(WORD_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(WORD_WIDTH-1){1'b1}}};
        end
    endfunction

    assign w_mrr = r_zr * r_zr;
    assign w_mii = r_zi * r_zi;
    assign w_mri = r_zr * r_zi;

    // Arithmetic shifts round toward minus infinity; the cross term keeps one
    // more bit, which doubles it.
    assign w_rr = sat_w(r_prr >>> FRAC_BITS);
    assign w_ii = sat_w(r_pii >>> FRAC_BITS);
    assign w_ri = sat_w(r_pri >>> (FRAC_BITS - 1));

    assign w_sum_re = PW'(w_rr) - PW'(w_ii) + PW'(r_cr);
    assign w_sum_im = PW'(w_ri) + PW'(r_ci);
    assign w_new_zr = sat_w(w_sum_re);
    assign w_new_zi = sat_w(w_sum_im);

    // The squares of the current z are exact and never negative.
    assign w_mag2 = {1'b0, r_prr} + {1'b0, r_pii};
    assign w_esc  = (w_mag2 >= ESC_LIM);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (i_mode) begin
                r_zr <= i_pt_re;
                r_zi <= i_pt_im;
                r_cr <= i_jc_re;
                r_ci <= i_jc_im;
            end else begin
                r_zr <= '0;
                r_zi <= '0;
                r_cr <= i_pt_re;
                r_ci <= i_pt_im;
            end
        end else if (i_cmd.step) begin
            r_zr <= w_new_zr;
            r_zi <= w_new_zi;
        end
        if (i_cmd.mul) begin
            r_prr <= w_mrr;
            r_pii <= w_mii;
            r_pri <= w_mri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + COUNT_WIDTH'(1);
        end
    end

    always_comb begin
        o_stat.escaped  = w_esc;
        o_stat.at_limit = (r_cnt == i_limit);
        o_stat.first    = (r_cnt == '0);
        o_res_esc       = (r_cnt != '0) && w_esc;
        // The iterate under test came from the iteration before the count.
        o_res_count     = o_res_esc ? (r_cnt - COUNT_WIDTH'(1)) : r_cnt;
    end

endmodule

[rtl/escape_time_fractal_iterator.sv]
// Top level of the escape-time fractal iterator: configuration registers,
// output register, and the controller and datapath. Depends on efi_pkg,
// efi_ctrl and efi_datapath.
//
//  Channel   Direction  Contents
//  s_axis    in         point_real, point_imag
//  m_axis    out        escape_count (tdata), did_escape (tuser)
//  APB       in/out     fractal_mode, julia_c_real, julia_c_imag, iteration_limit
//
// After a point is accepted, each iteration is a multiply step followed by an update
// step, until the point escapes or reaches the iteration limit; the result then goes
// to the output register.
// A new point is accepted while the previous result waits on m_axis.
// Reset is synchronous and active low; it restores the register defaults.
// A stalled m_axis holds the finished point in the controller until the
// output register frees up.
module escape_time_fractal_iterator #(
    parameter int WORD_WIDTH  = efi_pkg::DEF_WORD_WIDTH,
    parameter int FRAC_BITS   = efi_pkg::DEF_FRAC_BITS,
    parameter int COUNT_WIDTH = efi_pkg::DEF_COUNT_WIDTH,
    localparam int IN_TW      = ((2 * WORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW     = ((COUNT_WIDTH + 7) / 8) * 8,
    localparam int APB_DW     = (WORD_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_LSB   = (WORD_WIDTH > 32) ? 3 : 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // point_real [WORD_WIDTH-1:0], point_imag [2*WORD_WIDTH-1:WORD_WIDTH], zero fill
    input  logic [IN_TW-1:0]      s_axis_tdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // escape_count [COUNT_WIDTH-1:0], zero fill
    output logic [OUT_TW-1:0]     m_axis_tdata,
    // did_escape [0]
    output logic                  m_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_LSB+1:0]   paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);
    import efi_pkg::*;

    logic                          r_mode;
    logic signed [WORD_WIDTH-1:0]  r_jc_re;
    logic signed [WORD_WIDTH-1:0]  r_jc_im;
    logic        [COUNT_WIDTH-1:0] r_limit;
    logic                          r_out_valid;
    logic        [COUNT_WIDTH-1:0] r_out_count;
    logic                          r_out_esc;

    t_reg_idx                      w_idx;
    logic                          w_wr;
    logic                          w_out_free;
    logic                          w_out_load;
    t_dp_cmd                       w_cmd;
    t_dp_stat                      w_stat;
    logic        [COUNT_WIDTH-1:0] w_res_count;
    logic                          w_res_esc;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_LSB+1:ADDR_LSB]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_jc_re <= '0;
            r_jc_im <= '0;
            r_limit <= COUNT_WIDTH'(LIMIT_RESET);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MODE:   r_mode  <= pwdata[0];
                REG_C_REAL: r_jc_re <= pwdata[WORD_WIDTH-1:0];
                REG_C_IMAG: r_jc_im <= pwdata[WORD_WIDTH-1:0];
                REG_LIMIT:  r_limit <= pwdata[COUNT_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MODE:   prdata = APB_DW'(r_mode);
            REG_C_REAL: prdata = APB_DW'(r_jc_re);
            REG_C_IMAG: prdata = APB_DW'(r_jc_im);
            REG_LIMIT:  prdata = APB_DW'(r_limit);
            default:    prdata = '0;
        endcase
    end

    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_count <= w_res_count;
            r_out_esc   <= w_res_esc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TW'(r_out_count);
    assign m_axis_tuser  = r_out_esc;

    efi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_out_load (w_out_load),
        .o_cmd      (w_cmd)
    );

    efi_datapath #(
        .WORD_WIDTH  (WORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_mode      (r_mode),
        .i_jc_re     (r_jc_re),
        .i_jc_im     (r_jc_im),
        .i_limit     (r_limit),
        .i_pt_re     (s_axis_tdata[WORD_WIDTH-1:0]),
        .i_pt_im     (s_axis_tdata[2*WORD_WIDTH-1:WORD_WIDTH]),
        .o_stat      (w_stat),
        .o_res_count (w_res_count),
        .o_res_esc   (w_res_esc)
    );

endmodule

[dv/escape_time_fractal_iterator_test.sv]
`timescale 1ns / 1ps
// Testbench for escape_time_fractal_iterator: streams complex points into the iterator,
// predicts each escape count in Q4.28 fixed point and checks the result stream.
// Depends on efi_pkg and the RTL of the iterator.
module escape_time_fractal_iterator_test;
    import efi_pkg::*;

    localparam int WW           = DEF_WORD_WIDTH;
    localparam int FRAC         = DEF_FRAC_BITS;
    localparam int CW           = DEF_COUNT_WIDTH;
    localparam int RANDOM_ITEMS = 1425;
    localparam int QUIET_ITEMS  = 200;

    typedef logic [63:0] t_u64;

    typedef enum logic {
        MODE_MANDELBROT = 1'b0,
        MODE_JULIA      = 1'b1
    } t_fractal_mode;

    localparam logic [WW-1:0] W_ZERO     = 32'h0000_0000;
    localparam logic [WW-1:0] W_MAX      = 32'h7FFF_FFFF;
    localparam logic [WW-1:0] W_MIN      = 32'h8000_0000;
    localparam logic [WW-1:0] W_ONE      = 32'h1000_0000;
    localparam logic [WW-1:0] W_NEG_ONE  = 32'hF000_0000;
    localparam logic [WW-1:0] W_TWO      = 32'h2000_0000;
    localparam logic [WW-1:0] W_NEG_TWO  = 32'hE000_0000;
    localparam logic [WW-1:0] W_BELOW_2  = 32'h1FFF_FFFF;
    localparam logic [WW-1:0] W_QUARTER  = 32'h0400_0000;
    localparam logic [WW-1:0] W_TENTH    = 32'd26843546;
    localparam logic [WW-1:0] W_FIFTH    = 32'd53687091;
    localparam logic [WW-1:0] JC_RE      = 32'hF333_3333;  // about -0.8
    localparam logic [WW-1:0] JC_IM      = 32'd41875931;   // about 0.156
    localparam int unsigned   ONE_INT    = 268435456;
    localparam int unsigned   RE_SPAN    = 939524096;      // 3.5
    localparam int unsigned   RE_OFF     = 671088640;      // 2.5
    localparam int unsigned   IM_SPAN    = 805306368;      // 3.0
    localparam int unsigned   IM_OFF     = 402653184;      // 1.5
    localparam t_u64          ESCAPE_BOUND = t_u64'(4) << (2 * FRAC);

    typedef struct packed {
        logic [CW-1:0] count;
        logic          escaped;
    } t_escape_result;

    typedef struct packed {
        t_fractal_mode mode;
        logic [WW-1:0] c_re;
        logic [WW-1:0] c_im;
        logic [CW-1:0] limit;
        logic [WW-1:0] p_re;
        logic [WW-1:0] p_im;
        logic          known;
        logic [CW-1:0] want_count;
        logic          want_escape;
    } t_point_row;

    localparam int DIR_ROWS = 25;

    // Rows with known = 1 carry their result; the others go through the predictor.
    t_point_row directed_rows [DIR_ROWS] = '{
        '{MODE_MANDELBROT, W_ZERO, W_ZERO, 16'd256, W_ZERO, W_ZERO, 1'b1, 16'd256, 1'b0},
        '{MODE_MANDELBROT, W_ZERO, W_ZERO, 16'd256, W_MAX, W_MAX, 1'b1, 16'd0, 1'b1},
        '{MODE_MANDELBROT, W_ZERO, W_ZERO, 16'd256, W_MIN, W_MIN, 1'b1, 16'd0, 1'b1},
        '{MODE_MANDELBROT, W_ZERO, W_ZERO, 16'd256, W_MIN, W_MAX, 1'b1, 16'd0, 1'b1},
        '{MODE_MANDELBROT, W_ZERO, W_ZERO, 16'd256, W_MAX, W_ZERO, 1'b1, 16'd0, 1'b1},
        '{MODE_MANDELBROT, W_ZERO, W_ZERO, 16'd256, W_ZERO, W_MIN, 1'b1, 16'd0, 1'b1},
        '{MODE_MANDELBROT, W_ZERO, W_ZERO, 16'd256, W_TWO, W_ZERO, 1'b1, 16'd0, 1'b1},
        '{MODE_MANDELBROT, W_ZERO, W_ZERO, 16'd256, W_NEG_TWO, W_ZERO, 1'b1, 16'd0, 1'b1},
        '{MODE_MANDELBROT, W_ZERO, W_ZERO, 16'd256, W_BELOW_2, W_ZERO, 1'b0, 16'd0, 1'b0},
        '{MODE_MANDELBROT, W_ZERO, W_ZERO, 16'd256, W_QUARTER, W_ZERO, 1'b0, 16'd0, 1'b0},
        '{MODE_MANDELBROT, W_ZERO, W_ZERO, 16'd256, W_ZERO, W_ONE, 1'b0, 16'd0, 1'b0},
        '{MODE_MANDELBROT, W_ZERO, W_ZERO, 16'd256, 32'hFFFF_FFFF, 32'h1, 1'b0, 16'd0, 1'b0},
        '{MODE_MANDELBROT, W_ZERO, W_ZERO, 16'd0, W_MAX, W_MAX, 1'b1, 16'd0, 1'b0},
        '{MODE_MANDELBROT, W_ZERO, W_ZERO, 16'd0, W_ZERO, W_ZERO, 1'b1, 16'd0, 1'b0},
        '{MODE_MANDELBROT, W_ZERO, W_ZERO, 16'd1, W_ZERO, W_ZERO, 1'b1, 16'd1, 1'b0},
        '{MODE_MANDELBROT, W_ZERO, W_ZERO, 16'd16, W_NEG_ONE, W_ZERO, 1'b1, 16'd16, 1'b0},
        '{MODE_MANDELBROT, W_ZERO, W_ZERO, 16'd65535, W_ZERO, W_ZERO, 1'b1, 16'd65535, 1'b0},
        '{MODE_MANDELBROT, W_ZERO, W_ZERO, 16'd65535, W_MAX, W_MIN, 1'b1, 16'd0, 1'b1},
        '{MODE_JULIA, W_ZERO, W_ZERO, 16'd256, W_ZERO, W_ZERO, 1'b1, 16'd256, 1'b0},
        '{MODE_JULIA, W_ZERO, W_ZERO, 16'd1, W_ONE, W_ZERO, 1'b1, 16'd1, 1'b0},
        '{MODE_JULIA, W_MIN, W_MIN, 16'd256, W_ZERO, W_ZERO, 1'b1, 16'd0, 1'b1},
        '{MODE_JULIA, W_MAX, W_MAX, 16'd256, W_MAX, W_MAX, 1'b1, 16'd0, 1'b1},
        '{MODE_JULIA, JC_RE, JC_IM, 16'd256, W_TENTH, W_FIFTH, 1'b0, 16'd0, 1'b0},
        '{MODE_JULIA, JC_RE, JC_IM, 16'd256, W_MIN, W_ZERO, 1'b0, 16'd0, 1'b0},
        '{MODE_JULIA, JC_RE, JC_IM, 16'd256, W_NEG_ONE, W_QUARTER, 1'b0, 16'd0, 1'b0}
    };

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic [63:0]   s_axis_tdata = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [15:0]   m_axis_tdata;
    logic          m_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [3:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    t_escape_result pending_results [$];
    int             mismatches = 0;
    bit             idle_on = 1'b1;
    int             stall_left = 0;

    // Register copies as the block holds them.
    t_fractal_mode  cfg_mode = MODE_MANDELBROT;
    logic [WW-1:0]  cfg_c_re = '0;
    logic [WW-1:0]  cfg_c_im = '0;
    logic [CW-1:0]  cfg_limit = CW'(LIMIT_RESET);

    escape_time_fractal_iterator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint clamp_word(input longint v);
        if (v > longint'($signed(W_MAX))) return longint'($signed(W_MAX));
        if (v < longint'($signed(W_MIN))) return longint'($signed(W_MIN));
        return v;
    endfunction

    // Exact double-width products; an arithmetic shift gives the floor rounding.
    function automatic t_escape_result predict_escape(input logic [WW-1:0] p_re,
                                                      input logic [WW-1:0] p_im);
        longint         zr, zi, cr, ci, rr, ii, ri;
        t_u64           mag2;
        int             n;
        t_escape_result res;
        if (cfg_mode == MODE_JULIA) begin
            zr = longint'($signed(p_re));
            zi = longint'($signed(p_im));
            cr = longint'($signed(cfg_c_re));
            ci = longint'($signed(cfg_c_im));
        end else begin
            zr = 0;
            zi = 0;
            cr = longint'($signed(p_re));
            ci = longint'($signed(p_im));
        end
        res.escaped = 1'b0;
        for (n = 0; n < int'(cfg_limit); n++) begin
            rr = clamp_word((zr * zr) >>> FRAC);
            ii = clamp_word((zi * zi) >>> FRAC);
            ri = clamp_word((zr * zi) >>> (FRAC - 1));
            zr = clamp_word(rr - ii + cr);
            zi = clamp_word(ri + ci);
            mag2 = t_u64'(zr * zr) + t_u64'(zi * zi);
            if (mag2 >= ESCAPE_BOUND) begin
                res.escaped = 1'b1;
                break;
            end
        end
        res.count = n[CW-1:0];
        return res;
    endfunction

    task automatic send_point(input logic [WW-1:0] re, input logic [WW-1:0] im,
                              input t_escape_result want);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata = {im, re};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(want);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register, then read it back through the same port.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] mask;
        mask = (idx == REG_MODE) ? 32'h1 : (idx == REG_LIMIT) ? 32'hFFFF : 32'hFFFF_FFFF;
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((prdata & mask) != (value & mask)) begin
            $display("%0t: register %s readback expected %h, got %h",
                     $time, idx.name(), value & mask, prdata & mask);
            mismatches++;
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apply_config(input t_fractal_mode mode, input logic [WW-1:0] c_re,
                                input logic [WW-1:0] c_im, input logic [CW-1:0] limit);
        if (mode != cfg_mode || c_re != cfg_c_re || c_im != cfg_c_im || limit != cfg_limit) begin
            drain_results();
            if (mode != cfg_mode) write_reg(REG_MODE, 32'(mode));
            if (c_re != cfg_c_re) write_reg(REG_C_REAL, c_re);
            if (c_im != cfg_c_im) write_reg(REG_C_IMAG, c_im);
            if (limit != cfg_limit) write_reg(REG_LIMIT, 32'(limit));
            cfg_mode = mode;
            cfg_c_re = c_re;
            cfg_c_im = c_im;
            cfg_limit = limit;
        end
    endtask

    // Random result side back-pressure in bursts.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready = 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_axis_tready = 1'b0;
            stall_left = $urandom_range(0, 10);
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_escape_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none pending, expected nothing, got count %0d escape %0b",
                         $time, m_axis_tdata[CW-1:0], m_axis_tuser);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[CW-1:0] != want.count) begin
                    $display("%0t: escape_count expected %0d, got %0d",
                             $time, want.count, m_axis_tdata[CW-1:0]);
                    mismatches++;
                end
                if (m_axis_tuser != want.escaped) begin
                    $display("%0t: did_escape expected %0b, got %0b",
                             $time, want.escaped, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        t_point_row     row;
        t_escape_result want;
        logic [WW-1:0]  re, im, c_re, c_im;
        logic [CW-1:0]  limit;
        t_fractal_mode  mode;
        int             phase, items, sent;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            apply_config(row.mode, row.c_re, row.c_im, row.limit);
            if (row.known) begin
                want.count = row.want_count;
                want.escaped = row.want_escape;
            end else begin
                want = predict_escape(row.p_re, row.p_im);
            end
            send_point(row.p_re, row.p_im, want);
        end

        // Random phases, each with its own configuration written while the block is idle.
        sent = 0;
        for (phase = 0; sent < RANDOM_ITEMS; phase++) begin
            items = (phase == 2) ? 40 : 120;
            if (phase == 3 || phase == 4) mode = MODE_JULIA;
            else if (phase == 1) mode = MODE_MANDELBROT;
            else mode = t_fractal_mode'($urandom_range(0, 1));
            if (phase == 4) begin
                c_re = $urandom_range(0, 1) ? W_MAX : W_MIN;
                c_im = $urandom_range(0, 1) ? W_MAX : W_MIN;
            end else begin
                c_re = $urandom_range(0, 2 * ONE_INT) - ONE_INT;
                c_im = $urandom_range(0, 2 * ONE_INT) - ONE_INT;
            end
            if (phase == 0) limit = CW'(1);
            else if (phase == 2) limit = CW'(LIMIT_RESET);
            else limit = CW'($urandom_range(2, 64));
            apply_config(mode, c_re, c_im, limit);
            idle_on = (RANDOM_ITEMS - sent > QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < items && sent < RANDOM_ITEMS; k++) begin
                if (RANDOM_ITEMS - sent <= QUIET_ITEMS) idle_on = 1'b0;
                if ($urandom_range(0, 9) < 2) begin
                    re = $urandom;
                    im = $urandom;
                end else begin
                    // Most points land around the set where iterations run deep.
                    re = $urandom_range(0, RE_SPAN) - RE_OFF;
                    im = $urandom_range(0, IM_SPAN) - IM_OFF;
                end
                send_point(re, im, predict_escape(re, im));
                sent++;
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
